FILE: design/lru_page_buffer_pool_unit_macros.svh
// Assertion macros used by the pool top level
`ifndef LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH
`define LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH

// same-cycle implication
`define LPBP_ASSERT_IMP(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPBP_ASSERT_NXT(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lpbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpbp_pkg;

	localparam int FRAMES  = 64;
	localparam int TABLES  = 16;
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int TABLE_W = 4;
	localparam int PAGE_W  = 32;
	localparam int PIN_W   = 8;

	localparam logic [CNT_W-1:0]   FRAMES_C  = CNT_W'(FRAMES);
	localparam logic [CNT_W-1:0]   CAP_RESET = CNT_W'(64);
	localparam logic [TABLE_W:0]   TABLE_LIM = (TABLE_W + 1)'(TABLES);
	localparam logic [PIN_W-1:0]   PIN_MAX   = '1;

	// request codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic               op;
		logic [TABLE_W-1:0] tbl_id;
		logic [PAGE_W-1:0]  page_number;
		logic [5:0]         frame_slot;
		logic               set_dirty;
	} in_word_t;

	typedef struct packed {
		logic [5:0]         slot;
		logic               hit;
		logic               need_fill;
		logic               need_writeback;
		logic [TABLE_W-1:0] victim_table;
		logic [PAGE_W-1:0]  victim_page;
		logic [PIN_W-1:0]   pins;
	} out_word_t;

	// one frame as held in a recency cell
	typedef struct packed {
		logic [FRAME_W-1:0] fid;
		logic [TABLE_W-1:0] tbl;
		logic [PAGE_W-1:0]  pg;
		logic               dirty;
		logic [PIN_W-1:0]   pins;
	} entry_t;

	typedef enum logic [1:0] {
		UPD_NONE  = 2'd0,
		UPD_EDIT  = 2'd1,
		UPD_FRONT = 2'd2
	} upd_kind_t;

	// update broadcast to every cell
	typedef struct packed {
		upd_kind_t          kind;
		logic [FRAME_W-1:0] pos;
		entry_t             ent;
	} upd_ctl_t;

endpackage

`default_nettype wire

FILE: design/lpbp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One recency position. Position 0 is the newest frame; valid cells are
// contiguous from 0. A move to the front shifts cells 1..pos from their
// newer-side neighbour (the cell one place newer).
module lpbp_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [lpbp_pkg::FRAME_W-1:0] idx,
	input  wire lpbp_pkg::in_word_t           key,
	input  wire lpbp_pkg::upd_ctl_t           ctl,
	input  wire logic                         prev_vld,
	input  wire lpbp_pkg::entry_t             prev_ent,
	output logic                              vld,
	output lpbp_pkg::entry_t                  ent,
	output logic                              match
);

	logic             vld_q;
	lpbp_pkg::entry_t ent_q;

	// tag or frame-id compare for the lookup cycle
	always_comb begin
		if (key.op == lpbp_pkg::OP_RELEASE) begin
			match = vld_q && (ent_q.fid == key.frame_slot);
		end else begin
			match = vld_q && (ent_q.tbl == key.tbl_id) && (ent_q.pg == key.page_number);
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.kind == lpbp_pkg::UPD_FRONT) begin
			if (idx == '0) begin
				vld_q <= 1'b1;
			end else if (idx <= ctl.pos) begin
				vld_q <= prev_vld;
			end
		end
	end

	// frame contents
	always_ff @(posedge clk) begin
		case (ctl.kind)
			lpbp_pkg::UPD_FRONT: begin
				if (idx == '0) begin
					ent_q <= ctl.ent;
				end else if (idx <= ctl.pos) begin
					ent_q <= prev_ent;
				end
			end
			lpbp_pkg::UPD_EDIT: begin
				if (idx == ctl.pos) begin
					ent_q <= ctl.ent;
				end
			end
			default: begin
			end
		endcase
	end

	assign vld = vld_q;
	assign ent = ent_q;

endmodule

`default_nettype wire

FILE: design/lru_page_buffer_pool_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// The result word is strobed on done in ST_UPD, after ST_LOOK, which is entered
// at the accepting edge. A new word is taken while busy is low, also with done high;
// busy is high for the lookup cycle (tag compare across all recency cells), then the shift update.
// Reset clears every valid bit, the filled count and sets capacity to 64.
// done lasts one cycle; the receiver cannot stall.
module lru_page_buffer_pool_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire lpbp_pkg::in_word_t         req,
	output logic                            busy,
	output logic                            done,
	output lpbp_pkg::out_word_t             result,
	input  wire logic                       cfg_we,
	input  wire logic [lpbp_pkg::CNT_W-1:0] cfg_wdata
);

	`include "lru_page_buffer_pool_unit_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                         state_q;
	lpbp_pkg::in_word_t             req_q;
	lpbp_pkg::upd_ctl_t             ctl_q, ctl_d, ctl_cells;
	lpbp_pkg::out_word_t            res_q, res_d;
	logic                           inc_q, inc_d;
	logic [lpbp_pkg::CNT_W-1:0]     filled_q, cap_q, cap_eff;
	logic                           accept;

	logic [lpbp_pkg::FRAMES-1:0]    vlds, match, prev_vld, sel;
	lpbp_pkg::entry_t               ents     [lpbp_pkg::FRAMES];
	lpbp_pkg::entry_t               prev_ent [lpbp_pkg::FRAMES];
	logic [lpbp_pkg::FRAME_W-1:0]   idx_c    [lpbp_pkg::FRAMES];

	logic                           hit_any;
	logic [lpbp_pkg::FRAME_W-1:0]   hit_pos, vic_pos;
	lpbp_pkg::entry_t               rd;

	assign busy   = (state_q == ST_LOOK);
	assign accept = start && !busy;
	assign done   = (state_q == ST_UPD);
	assign result = res_q;

	// row of recency cells
	for (genvar k = 0; k < lpbp_pkg::FRAMES; k++) begin : g_cell
		assign idx_c[k] = lpbp_pkg::FRAME_W'(k);
		if (k == 0) begin : g_head
			assign prev_vld[k] = 1'b0;
			assign prev_ent[k] = '0;
		end else begin : g_link
			assign prev_vld[k] = vlds[k-1];
			assign prev_ent[k] = ents[k-1];
		end
		lpbp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (idx_c[k]),
			.key      (req_q),
			.ctl      (ctl_cells),
			.prev_vld (prev_vld[k]),
			.prev_ent (prev_ent[k]),
			.vld      (vlds[k]),
			.ent      (ents[k]),
			.match    (match[k])
		);
	end

	// the update reaches the cells only in the update cycle
	always_comb begin
		ctl_cells = ctl_q;
		if (state_q != ST_UPD) begin
			ctl_cells.kind = lpbp_pkg::UPD_NONE;
		end
	end

	// capacity clamp
	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) begin
			cap_eff = lpbp_pkg::CNT_W'(1);
		end else if (cap_q > lpbp_pkg::FRAMES_C) begin
			cap_eff = lpbp_pkg::FRAMES_C;
		end
	end

	// hit position and the selected cell's word
	assign hit_any = |match;
	assign vic_pos = lpbp_pkg::FRAME_W'(filled_q - 1'b1);

	always_comb begin
		hit_pos = '0;
		rd      = '0;
		for (int k = 0; k < lpbp_pkg::FRAMES; k++) begin
			sel[k] = hit_any ? match[k] : (idx_c[k] == vic_pos);
			if (match[k]) begin
				hit_pos = hit_pos | idx_c[k];
			end
			if (sel[k]) begin
				rd = lpbp_pkg::entry_t'(rd | ents[k]);
			end
		end
	end

	// lookup decision
	always_comb begin
		ctl_d      = '0;
		ctl_d.kind = lpbp_pkg::UPD_NONE;
		ctl_d.ent  = rd;
		res_d      = '0;
		inc_d      = 1'b0;
		if (req_q.op == lpbp_pkg::OP_RELEASE) begin
			res_d.slot = req_q.frame_slot;
			if ({1'b0, req_q.frame_slot} < filled_q) begin
				if (rd.pins != '0) begin
					ctl_d.ent.pins = rd.pins - 1'b1;
				end
				ctl_d.ent.dirty = rd.dirty | req_q.set_dirty;
				ctl_d.kind      = lpbp_pkg::UPD_EDIT;
				ctl_d.pos       = hit_pos;
				res_d.pins      = ctl_d.ent.pins;
			end
		end else if ({1'b0, req_q.tbl_id} < lpbp_pkg::TABLE_LIM) begin
			ctl_d.kind = lpbp_pkg::UPD_FRONT;
			if (hit_any) begin
				if (rd.pins != lpbp_pkg::PIN_MAX) begin
					ctl_d.ent.pins = rd.pins + 1'b1;
				end
				ctl_d.pos  = hit_pos;
				res_d.slot = rd.fid;
				res_d.hit  = 1'b1;
				res_d.pins = ctl_d.ent.pins;
			end else begin
				ctl_d.ent.tbl   = req_q.tbl_id;
				ctl_d.ent.pg    = req_q.page_number;
				ctl_d.ent.dirty = 1'b0;
				ctl_d.ent.pins  = lpbp_pkg::PIN_W'(1);
				res_d.need_fill = 1'b1;
				res_d.pins      = lpbp_pkg::PIN_W'(1);
				if (filled_q < cap_eff) begin
					// next unused frame
					ctl_d.ent.fid = filled_q[lpbp_pkg::FRAME_W-1:0];
					ctl_d.pos     = filled_q[lpbp_pkg::FRAME_W-1:0];
					inc_d         = 1'b1;
					res_d.slot    = filled_q[lpbp_pkg::FRAME_W-1:0];
				end else begin
					// evict the oldest frame
					ctl_d.ent.fid        = rd.fid;
					ctl_d.pos            = vic_pos;
					res_d.slot           = rd.fid;
					res_d.need_writeback = rd.dirty;
					res_d.victim_table   = rd.tbl;
					res_d.victim_page    = rd.pg;
				end
			end
		end
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			filled_q <= '0;
			cap_q    <= lpbp_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_IDLE, ST_UPD: begin
					if (state_q == ST_UPD && inc_q) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= accept ? ST_LOOK : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request word, decision and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_LOOK) begin
			ctl_q <= ctl_d;
			res_q <= res_d;
			inc_q <= inc_d;
		end
	end

	`LPBP_ASSERT_NXT(a_look_then_done, clk, arst_n, busy, done, "lookup not followed by result")
	`LPBP_ASSERT_IMP(a_fill_count, clk, arst_n, 1'b1, $countones(vlds) == filled_q, "valid cells disagree with fill count")
	`LPBP_ASSERT_IMP(a_tag_unique, clk, arst_n, busy, $onehot0(match), "more than one cell matched")

endmodule

`default_nettype wire
